FILE: design/hmf_pkg.sv
// Shared types and constants for the histogram mode finder.
// No dependencies; every other design file refers to it by scoped names.
package hmf_pkg;

    // Fixed field widths of the sample and result beats
    localparam int VALUE_W       = 7;
    localparam int COUNT_FIELD_W = 14;

    // Control part of a sample as it travels down the row of bin cells
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               hit;
        logic [VALUE_W-1:0] value;
    } hmf_beat_t;

endpackage

FILE: design/hmf_stream_if.sv
// Valid/ready channel interfaces for samples in and mode results out.
// Depends on hmf_pkg for the field widths.
interface hmf_sample_if;
    logic                        valid;
    logic                        ready;
    logic [hmf_pkg::VALUE_W-1:0] sample_value;
    logic                        last_of_set;

    modport source (output valid, output sample_value, output last_of_set, input ready);
    modport sink   (input valid, input sample_value, input last_of_set, output ready);
endinterface

interface hmf_mode_if;
    logic                              valid;
    logic                              ready;
    logic [hmf_pkg::VALUE_W-1:0]       mode_value;
    logic [hmf_pkg::COUNT_FIELD_W-1:0] mode_count;

    modport source (output valid, output mode_value, output mode_count, input ready);
    modport sink   (input valid, input mode_value, input mode_count, output ready);
endinterface

FILE: design/hmf_cell.sv
// One histogram bin: holds the occurrence count of a single value and passes
// each sample beat on to the next cell. Depends on hmf_pkg.
module hmf_cell #(
    parameter int INDEX      = 0,
    parameter int COUNT_BITS = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  hmf_pkg::hmf_beat_t     beat_in,
    input  logic [COUNT_BITS-1:0]  count_in,
    output hmf_pkg::hmf_beat_t     beat_out,
    output logic [COUNT_BITS-1:0]  count_out
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] bin_reg;
    logic [COUNT_BITS-1:0] bin_next;
    logic [COUNT_BITS-1:0] bin_inc;
    hmf_pkg::hmf_beat_t    beat_reg;
    hmf_pkg::hmf_beat_t    beat_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  hit_here;

    always_comb
    begin
        hit_here = beat_in.valid && (32'(beat_in.value) == 32'(INDEX));
        bin_inc  = (bin_reg == COUNT_MAX) ? bin_reg : bin_reg + 1'b1;

        beat_next     = beat_in;
        beat_next.hit = beat_in.hit | hit_here;
        count_next    = hit_here ? bin_inc : count_in;

        // The closing beat of a set leaves the bin empty behind it
        if (beat_in.valid && beat_in.last)
        begin
            bin_next = '0;
        end
        else if (hit_here)
        begin
            bin_next = bin_inc;
        end
        else
        begin
            bin_next = bin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_reg  <= '0;
            beat_reg <= '0;
        end
        else if (advance)
        begin
            bin_reg  <= bin_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_reg <= count_next;
        end
    end

    assign beat_out  = beat_reg;
    assign count_out = count_reg;

endmodule

FILE: design/hmf_mode_track.sv
// Tail of the bin row: keeps the running best value and count, and holds the
// mode result until it is taken. Depends on hmf_pkg and hmf_mode_if.
module hmf_mode_track #(
    parameter int COUNT_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hmf_pkg::hmf_beat_t    beat,
    input  logic [COUNT_BITS-1:0] count,
    output logic                  advance,
    hmf_mode_if.source            result
);

    logic [COUNT_BITS-1:0]             best_count_reg;
    logic [COUNT_BITS-1:0]             best_count_next;
    logic [hmf_pkg::VALUE_W-1:0]       best_value_reg;
    logic [hmf_pkg::VALUE_W-1:0]       best_value_next;
    logic [COUNT_BITS-1:0]             upd_count;
    logic [hmf_pkg::VALUE_W-1:0]       upd_value;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [hmf_pkg::VALUE_W-1:0]       mode_value_reg;
    logic [hmf_pkg::COUNT_FIELD_W-1:0] mode_count_reg;
    logic                              take;
    logic                              closing;

    always_comb
    begin
        // Stall the row only when a closing beat finds the result slot busy
        advance = !(beat.valid && beat.last && out_valid_reg && !result.ready);
        take    = advance && beat.valid;
        closing = take && beat.last;

        // Strictly greater: on a tie the earlier value keeps the mode
        if (beat.hit && (count > best_count_reg))
        begin
            upd_count = count;
            upd_value = beat.value;
        end
        else
        begin
            upd_count = best_count_reg;
            upd_value = best_value_reg;
        end

        best_count_next = best_count_reg;
        best_value_next = best_value_reg;
        if (closing)
        begin
            best_count_next = '0;
            best_value_next = '0;
        end
        else if (take)
        begin
            best_count_next = upd_count;
            best_value_next = upd_value;
        end

        out_valid_next = out_valid_reg && !result.ready;
        if (closing)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_count_reg <= '0;
            best_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_count_reg <= best_count_next;
            best_value_reg <= best_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (closing)
        begin
            mode_value_reg <= upd_value;
            mode_count_reg <= hmf_pkg::COUNT_FIELD_W'(upd_count);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.mode_value = mode_value_reg;
    assign result.mode_count = mode_count_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> (beat.valid && beat.last && out_valid_reg))
        else $error("row stalled without a blocked closing beat");

    a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        closing |=> (best_count_reg == '0 && best_value_reg == '0))
        else $error("best registers not cleared after a set");

    a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
        (best_count_reg == '0) |-> (best_value_reg == '0))
        else $error("best value set without a count");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (beat.valid && beat.hit) |-> (count != '0))
        else $error("counted beat arrived with a zero count");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        closing |=> out_valid_reg)
        else $error("closing beat produced no result");

endmodule

FILE: design/histogram_mode_finder.sv
// Histogram mode finder: takes one sample beat per cycle, counts each value
// in a row of VALUE_COUNT bin cells that the beat walks through one cell a
// cycle, and on a beat marked last_of_set delivers the value that first
// reached the highest count, with that count (saturating at COUNT_BITS).
// Samples at or above VALUE_COUNT are not counted. A result is registered
// once its closing beat has passed the last bin cell; the bins clear
// behind the closing beat, so the next set may follow in the next cycle.
// Input is stalled only while a closing beat at the end of the row waits for
// the previous result to be taken. Depends on hmf_pkg, hmf_stream_if,
// hmf_cell and hmf_mode_track.
module histogram_mode_finder #(
    parameter int VALUE_COUNT = 128,
    parameter int COUNT_BITS  = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    hmf_sample_if.sink  samples,
    hmf_mode_if.source  result
);

    hmf_pkg::hmf_beat_t    chain_beat  [VALUE_COUNT+1];
    logic [COUNT_BITS-1:0] chain_count [VALUE_COUNT+1];
    logic                  advance;

    assign samples.ready = advance;

    always_comb
    begin
        chain_beat[0].valid = samples.valid && advance;
        chain_beat[0].last  = samples.last_of_set;
        chain_beat[0].hit   = 1'b0;
        chain_beat[0].value = samples.sample_value;
        chain_count[0]      = '0;
    end

    for (genvar k = 0; k < VALUE_COUNT; k++)
    begin : g_bin
        hmf_cell #(
            .INDEX      (k),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .beat_in   (chain_beat[k]),
            .count_in  (chain_count[k]),
            .beat_out  (chain_beat[k+1]),
            .count_out (chain_count[k+1])
        );
    end

    hmf_mode_track #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mode_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (chain_beat[VALUE_COUNT]),
        .count   (chain_count[VALUE_COUNT]),
        .advance (advance),
        .result  (result)
    );

endmodule

FILE: tb/tb_histogram_mode_finder.sv
// Self-checking testbench for histogram_mode_finder: drives sample beats, predicts the
// mode of each set and compares every result beat against that prediction.
// Depends on hmf_pkg, hmf_stream_if and the histogram_mode_finder design files.
module tb_histogram_mode_finder;

    localparam int VALUE_COUNT = 128;
    localparam int COUNT_BITS  = 14;
    localparam int VALUE_W     = hmf_pkg::VALUE_W;
    localparam int COUNT_W     = hmf_pkg::COUNT_FIELD_W;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } mode_result_t;

    class mode_scoreboard;
        logic [COUNT_BITS-1:0] bin_count [VALUE_COUNT];
        logic [COUNT_BITS-1:0] top_count;
        logic [VALUE_W-1:0]    top_value;
        mode_result_t          expected_modes [$];
        int                    error_count;
        int                    samples_seen;
        int                    sets_checked;

        function new();
            error_count  = 0;
            samples_seen = 0;
            sets_checked = 0;
            clear_bins();
        endfunction

        function void clear_bins();
            foreach (bin_count[i])
                bin_count[i] = '0;
            top_count = '0;
            top_value = '0;
        endfunction

        function void note_sample(logic [VALUE_W-1:0] value, logic last);
            mode_result_t mode;
            samples_seen++;
            if (int'(value) < VALUE_COUNT)
            begin
                // hold a saturated bin; it can then never beat the current leader
                if (bin_count[value] != {COUNT_BITS{1'b1}})
                    bin_count[value] = bin_count[value] + 1'b1;
                if (bin_count[value] > top_count)
                begin
                    top_count = bin_count[value];
                    top_value = value;
                end
            end
            if (last)
            begin
                mode.value = top_value;
                mode.count = top_count[COUNT_W-1:0];
                expected_modes.push_back(mode);
                clear_bins();
            end
        endfunction

        function void check_result(logic [VALUE_W-1:0] value, logic [COUNT_W-1:0] count);
            mode_result_t mode;
            if (expected_modes.size() == 0)
            begin
                $error("unexpected result beat: mode_value %0d mode_count %0d", value, count);
                error_count++;
                return;
            end
            mode = expected_modes.pop_front();
            sets_checked++;
            if (value !== mode.value)
            begin
                $error("mode_value: expected %0d, actual %0d", mode.value, value);
                error_count++;
            end
            if (count !== mode.count)
            begin
                $error("mode_count: expected %0d, actual %0d", mode.count, count);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_modes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   hold_cycles;
    int   stall_left;

    mode_scoreboard sb;

    hmf_sample_if samples_ch ();
    hmf_mode_if   result_ch ();

    histogram_mode_finder #(
        .VALUE_COUNT (VALUE_COUNT),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .result  (result_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: a long hold-off takes priority over short random stalls
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ch.ready = 1'b0;
            hold_cycles--;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready = 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            result_ch.ready = 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
        end
        else
            result_ch.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.mode_value, result_ch.mode_count);
    end

    task automatic send_sample(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            samples_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples_ch.valid        = 1'b1;
        samples_ch.sample_value = value;
        samples_ch.last_of_set  = last;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        sb.note_sample(value, last);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        samples_ch.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly sets drawn from a narrow window so that repeats and ties are common
    task automatic send_random_sets(input int target, input int max_len);
        int                 sent;
        int                 len;
        int                 base;
        int                 span;
        logic [VALUE_W-1:0] value;
        sent = 0;
        while (sent < target)
        begin
            len  = $urandom_range(1, max_len);
            base = $urandom_range(0, VALUE_COUNT - 1);
            span = ($urandom_range(0, 2) == 0) ? VALUE_COUNT - 1 : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if (span == VALUE_COUNT - 1)
                    value = VALUE_W'($urandom_range(0, VALUE_COUNT - 1));
                else
                    value = VALUE_W'(base + int'($urandom_range(0, span)));
                send_sample(value, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        sb                      = new();
        idle_on                 = 1'b1;
        hold_cycles             = 0;
        stall_left              = 0;
        rst_n                   = 1'b0;
        samples_ch.valid        = 1'b0;
        samples_ch.sample_value = '0;
        samples_ch.last_of_set  = 1'b0;
        result_ch.ready         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-beat sets at both value extremes
        send_sample(7'd0, 1'b1);
        send_sample(7'd127, 1'b1);
        // ties: whichever value reaches the count first keeps the mode
        send_sample(7'd5, 1'b0);
        send_sample(7'd9, 1'b0);
        send_sample(7'd9, 1'b0);
        send_sample(7'd5, 1'b1);
        send_sample(7'd5, 1'b0);
        send_sample(7'd9, 1'b0);
        send_sample(7'd5, 1'b0);
        send_sample(7'd9, 1'b1);
        // a later value overtakes only by strictly exceeding
        send_sample(7'd3, 1'b0);
        send_sample(7'd3, 1'b0);
        send_sample(7'd3, 1'b0);
        send_sample(7'd127, 1'b0);
        send_sample(7'd127, 1'b0);
        send_sample(7'd127, 1'b0);
        send_sample(7'd127, 1'b1);
        send_sample(7'd85, 1'b0);
        send_sample(7'd42, 1'b0);
        send_sample(7'd42, 1'b0);
        send_sample(7'd85, 1'b0);
        send_sample(7'd85, 1'b1);
        stop_sending();
        drain_results();

        send_random_sets(220, 12);

        // long receiver hold-off with short sets so the row backs up to the input
        hold_cycles = 400;
        send_random_sets(120, 3);
        stop_sending();
        drain_results();

        send_random_sets(80, 24);

        idle_on = 1'b0;
        send_random_sets(80, 12);
        stop_sending();
        drain_results();
        repeat (VALUE_COUNT + 16) @(posedge clk);

        $display("Checked %0d mode results from %0d sample beats: ties, value extremes,",
                 sb.sets_checked, sb.samples_seen);
        $display("random sets with stalls, a full back-pressure phase and a gap-free tail.");
        if (sb.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
